[hdl/amt_pkg.sv]
`default_nettype none
package amt_pkg;

   localparam int MAX_RADIUS_DEF = 7;
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT     = 4096;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int RADIUS_W = 3;
   localparam int SCALE_W  = 16;
   localparam int WIDTH_W  = 12;
   localparam int HEIGHT_W = 13;

   localparam int PIXEL_W = 8;

   localparam logic [RADIUS_W-1:0] RADIUS_RST = 3'd2;
   localparam logic [SCALE_W-1:0]  SCALE_RST  = 16'd3686;
   localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

   localparam logic [PIXEL_W-1:0] PIXEL_ON  = 8'd255;
   localparam logic [PIXEL_W-1:0] PIXEL_OFF = 8'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RADIUS = 2'd0,
      CSR_SCALE  = 2'd1,
      CSR_WIDTH  = 2'd2,
      CSR_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } operation_type;

endpackage
`default_nettype wire

[hdl/amt_req_if.sv]
`default_nettype none
interface amt_req_if;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [amt_pkg::PIXEL_W-1:0]  pixel_value;

   modport source (output valid, output operation, output pixel_value, input ready);
   modport sink   (input valid, input operation, input pixel_value, output ready);
endinterface
`default_nettype wire

[hdl/amt_rsp_if.sv]
`default_nettype none
interface amt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [amt_pkg::PIXEL_W-1:0]  binary_pixel;
   logic                         frame_last;

   modport source (output valid, output binary_pixel, output frame_last, input ready);
   modport sink   (input valid, input binary_pixel, input frame_last, output ready);
endinterface
`default_nettype wire

[hdl/adaptive_mean_threshold_unit.sv]
// channel | dir | handshake          | payload
// req_ch  | in  | valid/ready        | operation, pixel_value
// rsp_ch  | out | valid/ready        | binary_pixel, frame_last
// csr     | in  | csr_we, no wait    | csr_index, csr_wdata
//
// A request that yields no result leaves the unit idle. A request that yields a result runs
// one line store read per window tap, a read of the centre pixel, then one quotient
// bit per cycle of the mean division, then the scale multiply.
// Reset is synchronous; it restores the register defaults and starts a new frame.
// No clearing pass: only pixels written in the current frame are read.
// A new request is taken while a result waits in the output register; the next result
// holds until the previous one is taken.
`default_nettype none
module adaptive_mean_threshold_unit #(
   parameter int MAX_RADIUS = amt_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = amt_pkg::MAX_WIDTH_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   amt_req_if.sink                            req_ch,
   amt_rsp_if.source                          rsp_ch,
   input  wire                                csr_we,
   input  wire [amt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [amt_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int ROWS   = 2 * MAX_RADIUS + 2;
   localparam int SLW    = $clog2(ROWS);
   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = amt_pkg::HEIGHT_W;
   localparam int RW     = $clog2(MAX_RADIUS + 1);
   localparam int KW     = RW + 1;
   localparam int KKMAX  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int KKW    = $clog2(KKMAX + 1);
   localparam int SUM_W  = $clog2(KKMAX * 255 + 1);
   localparam int DCW    = $clog2(SUM_W + 1);
   localparam int TW     = WW + HW;
   localparam int DEPTH  = ROWS * MAX_WIDTH;
   localparam int AW     = $clog2(DEPTH);
   localparam int XW     = CW + 2;
   localparam int YW     = HW + 2;
   localparam int PW     = amt_pkg::PIXEL_W;
   localparam int MW     = amt_pkg::SCALE_W + SUM_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SUM, ST_CTR, ST_WAIT, ST_DIV, ST_MUL, ST_OUT
   } state_type;

   state_type                    state_ff;
   logic [amt_pkg::RADIUS_W-1:0] radius_ff;
   logic [amt_pkg::SCALE_W-1:0]  scale_ff;
   logic [amt_pkg::WIDTH_W-1:0]  width_ff;
   logic [amt_pkg::HEIGHT_W-1:0] height_ff;

   logic [TW-1:0]  in_count_ff;
   logic [CW-1:0]  in_col_ff;
   logic [SLW-1:0] in_slot_ff;
   logic [TW-1:0]  out_count_ff;
   logic [CW-1:0]  out_col_ff;
   logic [HW-1:0]  out_row_ff;
   logic [SLW-1:0] out_slot_ff;

   logic [KW-1:0]         ia_ff;
   logic [KW-1:0]         ib_ff;
   logic signed [YW-1:0]  y_ff;
   logic signed [XW-1:0]  x_ff;
   logic [SLW-1:0]        yslot_ff;
   logic                  add_ff;
   logic                  ctr_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [PW-1:0]         pix_ff;
   logic [SUM_W-1:0]      dq_ff;
   logic [KKW-1:0]        drem_ff;
   logic [DCW-1:0]        dcnt_ff;
   logic [MW-1:0]         prod_ff;
   logic                  rsp_valid_ff;
   logic [PW-1:0]         rsp_pixel_ff;
   logic                  rsp_last_ff;

   logic [PW-1:0] line_mem [DEPTH];
   logic [PW-1:0] mem_q_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;

   logic [RW-1:0]  r_eff;
   logic [WW-1:0]  w_eff;
   logic [HW-1:0]  h_eff;
   logic [KW-1:0]  k_eff;
   logic [KKW-1:0] kk_eff;
   logic [TW-1:0]  total;
   logic [TW-1:0]  lag;
   logic [KW-1:0]  span;
   logic           req_fire;
   logic           pix_ok;
   logic           drain_ok;
   logic           tap_ok;
   logic           out_free;
   logic           out_last;
   logic [SLW-1:0] start_slot;
   logic [KKW:0]   trial;
   logic           trial_ge;
   logic [CW-1:0]  raddr_col;
   logic [SLW-1:0] raddr_slot;

   always_comb begin
      r_eff  = (32'(radius_ff) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_ff);
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(height_ff) > amt_pkg::MAX_HEIGHT) begin
         h_eff = HW'(amt_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      k_eff  = {r_eff, 1'b1};
      kk_eff = KKW'(k_eff) * KKW'(k_eff);
      total  = TW'(w_eff) * TW'(h_eff);
      lag    = TW'(r_eff) * TW'(w_eff) + TW'(r_eff);
      span   = {r_eff, 1'b0};
   end

   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign pix_ok   = (req_ch.operation == amt_pkg::OP_PIXEL) && (in_count_ff < total);
   assign drain_ok = (req_ch.operation == amt_pkg::OP_DRAIN) && (in_count_ff >= total)
                     && (out_count_ff < total);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign out_last = (out_count_ff + TW'(1)) >= total;
   assign start_slot = (out_slot_ff >= SLW'(r_eff)) ? out_slot_ff - SLW'(r_eff)
                                                    : out_slot_ff + SLW'(ROWS) - SLW'(r_eff);
   assign tap_ok = !y_ff[YW-1] && ($unsigned(y_ff) < YW'(h_eff))
                   && !x_ff[XW-1] && ($unsigned(x_ff) < XW'(w_eff));
   assign trial    = {drem_ff, dq_ff[SUM_W-1]};
   assign trial_ge = trial >= (KKW+1)'(kk_eff);

   always_comb begin
      if (state_ff == ST_CTR) begin
         raddr_slot = out_slot_ff;
         raddr_col  = out_col_ff;
      end else begin
         raddr_slot = yslot_ff;
         raddr_col  = x_ff[CW-1:0];
      end
   end

   assign mem_we    = req_fire && pix_ok;
   assign mem_waddr = AW'(in_slot_ff) * AW'(MAX_WIDTH) + AW'(in_col_ff);
   assign mem_raddr = AW'(raddr_slot) * AW'(MAX_WIDTH) + AW'(raddr_col);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= req_ch.pixel_value;
      end
      mem_q_ff <= line_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= amt_pkg::RADIUS_RST;
         scale_ff     <= amt_pkg::SCALE_RST;
         width_ff     <= amt_pkg::WIDTH_RST;
         height_ff    <= amt_pkg::HEIGHT_RST;
         in_count_ff  <= '0;
         in_col_ff    <= '0;
         in_slot_ff   <= '0;
         out_count_ff <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         add_ff       <= 1'b0;
         ctr_ff       <= 1'b0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         add_ff <= 1'b0;
         ctr_ff <= 1'b0;
         if (add_ff) begin
            sum_ff <= sum_ff + SUM_W'(mem_q_ff);
         end
         if (ctr_ff) begin
            pix_ff <= mem_q_ff;
         end
         if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_we) begin
            case (csr_index)
               amt_pkg::CSR_RADIUS: radius_ff <= csr_wdata[amt_pkg::RADIUS_W-1:0];
               amt_pkg::CSR_SCALE:  scale_ff  <= csr_wdata[amt_pkg::SCALE_W-1:0];
               amt_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[amt_pkg::WIDTH_W-1:0];
               amt_pkg::CSR_HEIGHT: height_ff <= csr_wdata[amt_pkg::HEIGHT_W-1:0];
               default: ;
            endcase
            in_count_ff  <= '0;
            in_col_ff    <= '0;
            in_slot_ff   <= '0;
            out_count_ff <= '0;
            out_col_ff   <= '0;
            out_row_ff   <= '0;
            out_slot_ff  <= '0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire && (pix_ok || drain_ok)) begin
                  if (pix_ok) begin
                     in_count_ff <= in_count_ff + TW'(1);
                     if (WW'(in_col_ff) + WW'(1) >= w_eff) begin
                        in_col_ff  <= '0;
                        in_slot_ff <= (in_slot_ff == SLW'(ROWS - 1)) ? '0
                                                                     : in_slot_ff + SLW'(1);
                     end else begin
                        in_col_ff <= in_col_ff + CW'(1);
                     end
                  end
                  if (drain_ok || ((in_count_ff + TW'(1)) > lag)) begin
                     state_ff <= ST_SUM;
                     ia_ff    <= '0;
                     ib_ff    <= '0;
                     y_ff     <= $signed(YW'(out_row_ff)) - $signed(YW'(r_eff));
                     x_ff     <= $signed(XW'(out_col_ff)) - $signed(XW'(r_eff));
                     yslot_ff <= start_slot;
                     sum_ff   <= '0;
                  end
               end
            end
            ST_SUM: begin
               add_ff <= tap_ok;
               if (ib_ff == span) begin
                  ib_ff    <= '0;
                  x_ff     <= $signed(XW'(out_col_ff)) - $signed(XW'(r_eff));
                  y_ff     <= y_ff + YW'(1);
                  yslot_ff <= (yslot_ff == SLW'(ROWS - 1)) ? '0 : yslot_ff + SLW'(1);
                  ia_ff    <= ia_ff + KW'(1);
                  if (ia_ff == span) begin
                     state_ff <= ST_CTR;
                  end
               end else begin
                  ib_ff <= ib_ff + KW'(1);
                  x_ff  <= x_ff + XW'(1);
               end
            end
            ST_CTR: begin
               ctr_ff   <= 1'b1;
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               dq_ff    <= sum_ff;
               drem_ff  <= '0;
               dcnt_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               drem_ff <= trial_ge ? KKW'(trial - (KKW+1)'(kk_eff)) : KKW'(trial);
               dq_ff   <= {dq_ff[SUM_W-2:0], trial_ge};
               dcnt_ff <= dcnt_ff + DCW'(1);
               if (dcnt_ff == DCW'(SUM_W - 1)) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= MW'(scale_ff) * MW'(dq_ff);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pixel_ff <= (MW'({pix_ff, 12'd0}) > prod_ff) ? amt_pkg::PIXEL_ON
                                                                   : amt_pkg::PIXEL_OFF;
                  rsp_last_ff  <= out_last;
                  state_ff     <= ST_IDLE;
                  if (out_last) begin
                     in_count_ff  <= '0;
                     in_col_ff    <= '0;
                     in_slot_ff   <= '0;
                     out_count_ff <= '0;
                     out_col_ff   <= '0;
                     out_row_ff   <= '0;
                     out_slot_ff  <= '0;
                  end else begin
                     out_count_ff <= out_count_ff + TW'(1);
                     if (WW'(out_col_ff) + WW'(1) >= w_eff) begin
                        out_col_ff  <= '0;
                        out_row_ff  <= out_row_ff + HW'(1);
                        out_slot_ff <= (out_slot_ff == SLW'(ROWS - 1)) ? '0
                                                                       : out_slot_ff + SLW'(1);
                     end else begin
                        out_col_ff <= out_col_ff + CW'(1);
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.binary_pixel = rsp_pixel_ff;
   assign rsp_ch.frame_last   = rsp_last_ff;

   a_in_bound: assert property (@(posedge clock) disable iff (reset)
      in_count_ff <= total)
      else $error("input count past frame size");

   a_out_behind: assert property (@(posedge clock) disable iff (reset)
      out_count_ff <= in_count_ff)
      else $error("output position ahead of input");

   a_pixel_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pixel_ff == amt_pkg::PIXEL_ON || rsp_pixel_ff == amt_pkg::PIXEL_OFF))
      else $error("result pixel not binary");

   a_tap_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (ia_ff <= span && ib_ff <= span))
      else $error("window tap index out of range");

   a_sum_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (!add_ff && !ctr_ff))
      else $error("division started with reads in flight");

endmodule
`default_nettype wire

[tb/tb_adaptive_mean_threshold_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_adaptive_mean_threshold_unit;

   localparam int RING_DEPTH   = 2 * amt_pkg::MAX_RADIUS_DEF * amt_pkg::MAX_WIDTH_DEF
                                 + 2 * amt_pkg::MAX_RADIUS_DEF + 1;
   localparam int SETTLE_WAIT  = 300;
   localparam int WATCHDOG_MAX = 5000;
   localparam int RANDOM_ITEMS = 1450;

   typedef struct packed {
      amt_pkg::operation_type          op;
      logic [amt_pkg::PIXEL_W-1:0]     pix;
   } pixel_request_type;

   typedef struct packed {
      logic [amt_pkg::PIXEL_W-1:0]     binary_pixel;
      logic                            frame_last;
   } threshold_result_type;

   logic                                clock;
   logic                                reset;
   logic                                csr_we;
   logic [amt_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [amt_pkg::CSR_DATA_W-1:0]      csr_wdata;

   amt_req_if req_if();
   amt_rsp_if rsp_if();

   adaptive_mean_threshold_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pixel_request_type      pending_reqs[$];
   threshold_result_type   expected_pixels[$];

   logic [amt_pkg::PIXEL_W-1:0]  ring_pixels [RING_DEPTH];
   logic [amt_pkg::RADIUS_W-1:0] cfg_radius;
   logic [amt_pkg::SCALE_W-1:0]  cfg_scale;
   logic [amt_pkg::WIDTH_W-1:0]  cfg_width;
   logic [amt_pkg::HEIGHT_W-1:0] cfg_height;
   int unsigned                  in_row, in_col, out_pos;

   int  n_req_queued, n_req_acc, n_rsp_acc, n_frames, n_cfg_writes;
   int  n_errors;
   int  req_gap, rsp_gap, hold_left, idle_cycles;
   bit  calm, hold_done;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int unsigned eff_radius();
      return (cfg_radius > amt_pkg::MAX_RADIUS_DEF) ? amt_pkg::MAX_RADIUS_DEF : cfg_radius;
   endfunction

   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      return (cfg_width > amt_pkg::MAX_WIDTH_DEF) ? amt_pkg::MAX_WIDTH_DEF : cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      if (cfg_height == 0) return 1;
      return (cfg_height > amt_pkg::MAX_HEIGHT) ? amt_pkg::MAX_HEIGHT : cfg_height;
   endfunction

   function automatic logic [amt_pkg::PIXEL_W-1:0] rand_pixel();
      logic [31:0] v;
      v = $urandom;
      return v[amt_pkg::PIXEL_W-1:0];
   endfunction

   function automatic void emit_threshold();
      int unsigned w, h, r, k, oi, oj, sum, mean;
      int          y, x;
      longint unsigned lhs, rhs;
      threshold_result_type res;
      w = eff_width();
      h = eff_height();
      r = eff_radius();
      k = 2 * r + 1;
      oi = out_pos / w;
      oj = out_pos % w;
      sum = 0;
      for (int a = -int'(r); a <= int'(r); a++) begin
         y = int'(oi) + a;
         if (y < 0 || y >= int'(h)) continue;
         for (int b = -int'(r); b <= int'(r); b++) begin
            x = int'(oj) + b;
            if (x < 0 || x >= int'(w)) continue;
            sum += ring_pixels[(y * w + x) % RING_DEPTH];
         end
      end
      mean = sum / (k * k);
      lhs = longint'(ring_pixels[out_pos % RING_DEPTH]) * 4096;
      rhs = longint'(cfg_scale) * mean;
      res.binary_pixel = (lhs > rhs) ? amt_pkg::PIXEL_ON : amt_pkg::PIXEL_OFF;
      out_pos++;
      if (out_pos >= w * h) begin
         res.frame_last = 1'b1;
         in_row = 0;
         in_col = 0;
         out_pos = 0;
      end else begin
         res.frame_last = 1'b0;
      end
      expected_pixels.push_back(res);
   endfunction

   function automatic void predict_threshold(amt_pkg::operation_type op,
                                             logic [amt_pkg::PIXEL_W-1:0] pix);
      int unsigned w, total, lag, count;
      w = eff_width();
      total = w * eff_height();
      lag = eff_radius() * w + eff_radius();
      count = in_row * w + in_col;
      if (op == amt_pkg::OP_PIXEL) begin
         if (count >= total) return;
         ring_pixels[count % RING_DEPTH] = pix;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         count++;
         if (count > lag) emit_threshold();
      end else if (count >= total && out_pos < total) begin
         emit_threshold();
      end
   endfunction

   task automatic queue_request(amt_pkg::operation_type op, logic [amt_pkg::PIXEL_W-1:0] pix);
      pixel_request_type item;
      item.op = op;
      item.pix = pix;
      predict_threshold(op, pix);
      pending_reqs.push_back(item);
      n_req_queued++;
   endtask

   task automatic wait_idle();
      while (n_req_acc != n_req_queued || expected_pixels.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(amt_pkg::csr_index_type idx,
                            logic [amt_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         amt_pkg::CSR_RADIUS: cfg_radius = value[amt_pkg::RADIUS_W-1:0];
         amt_pkg::CSR_SCALE:  cfg_scale  = value[amt_pkg::SCALE_W-1:0];
         amt_pkg::CSR_WIDTH:  cfg_width  = value[amt_pkg::WIDTH_W-1:0];
         amt_pkg::CSR_HEIGHT: cfg_height = value[amt_pkg::HEIGHT_W-1:0];
         default: ;
      endcase
      in_row = 0;
      in_col = 0;
      out_pos = 0;
      n_cfg_writes++;
   endtask

   task automatic configure(int r, int scale, int w, int h);
      wait_idle();
      calm = ($urandom_range(0, 4) == 0);
      write_reg(amt_pkg::CSR_RADIUS, r[amt_pkg::CSR_DATA_W-1:0]);
      write_reg(amt_pkg::CSR_SCALE, scale[amt_pkg::CSR_DATA_W-1:0]);
      write_reg(amt_pkg::CSR_WIDTH, w[amt_pkg::CSR_DATA_W-1:0]);
      write_reg(amt_pkg::CSR_HEIGHT, h[amt_pkg::CSR_DATA_W-1:0]);
   endtask

   task automatic send_frame();
      int unsigned total;
      total = eff_width() * eff_height();
      for (int i = 0; i < total; i++) begin
         if ($urandom_range(0, 9) == 0) queue_request(amt_pkg::OP_DRAIN, rand_pixel());
         queue_request(amt_pkg::OP_PIXEL, rand_pixel());
      end
      if ((in_row != 0 || in_col != 0 || out_pos != 0) && $urandom_range(0, 5) == 0)
         queue_request(amt_pkg::OP_PIXEL, rand_pixel());
      do begin
         queue_request(amt_pkg::OP_DRAIN, rand_pixel());
      end while (in_row != 0 || in_col != 0 || out_pos != 0);
   endtask

   function automatic int pick_gap();
      if (calm) return 0;
      case ($urandom_range(0, 19))
         0:       return $urandom_range(10, 40);
         1, 2, 3,
         4, 5:    return $urandom_range(1, 3);
         default: return 0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) n_req_acc++;
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               pixel_request_type item;
               item = pending_reqs.pop_front();
               req_if.valid       <= 1'b1;
               req_if.operation   <= item.op;
               req_if.pixel_value <= item.pix;
               req_gap = pick_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_gap = 0;
         hold_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            threshold_result_type exp_res;
            n_rsp_acc++;
            if (rsp_if.frame_last) n_frames++;
            if (expected_pixels.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("ERROR: unexpected result pixel=%0d last=%0b",
                           rsp_if.binary_pixel, rsp_if.frame_last);
            end else begin
               exp_res = expected_pixels.pop_front();
               if (rsp_if.binary_pixel !== exp_res.binary_pixel ||
                   rsp_if.frame_last !== exp_res.frame_last) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("ERROR: result %0d expected %0d/%0b got %0d/%0b",
                              n_rsp_acc, exp_res.binary_pixel, exp_res.frame_last,
                              rsp_if.binary_pixel, rsp_if.frame_last);
               end
            end
            if (n_rsp_acc == 150 && !hold_done) begin
               hold_done = 1'b1;
               hold_left = 800;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            rsp_gap = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Watchdog: no progress for %0d cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      req_if.valid       = 1'b0;
      req_if.operation   = amt_pkg::OP_PIXEL;
      req_if.pixel_value = '0;
      rsp_if.ready       = 1'b0;
      csr_we             = 1'b0;
      csr_index          = amt_pkg::CSR_RADIUS;
      csr_wdata          = '0;
      cfg_radius = amt_pkg::RADIUS_RST;
      cfg_scale  = amt_pkg::SCALE_RST;
      cfg_width  = amt_pkg::WIDTH_RST;
      cfg_height = amt_pkg::HEIGHT_RST;
      in_row = 0;
      in_col = 0;
      out_pos = 0;
      idle_cycles = 0;
      calm = 1'b0;
      hold_done = 1'b0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset: far from the lag, no results
      for (int i = 0; i < 8; i++) queue_request(amt_pkg::OP_PIXEL, i[0] ? 8'd255 : 8'd0);
      queue_request(amt_pkg::OP_DRAIN, 8'd0);

      // zero width and height act as one, zero radius
      configure(0, 4096, 0, 0);
      queue_request(amt_pkg::OP_PIXEL, 8'd255);
      queue_request(amt_pkg::OP_PIXEL, 8'd0);
      queue_request(amt_pkg::OP_DRAIN, 8'd0);

      // pixel after frame is in, drain before frame is in, extra drain
      configure(1, 65535, 3, 2);
      queue_request(amt_pkg::OP_PIXEL, 8'd255);
      queue_request(amt_pkg::OP_DRAIN, 8'd0);
      for (int i = 0; i < 5; i++) queue_request(amt_pkg::OP_PIXEL, 8'd255 - i[7:0]);
      queue_request(amt_pkg::OP_PIXEL, 8'd7);
      for (int i = 0; i < 5; i++) queue_request(amt_pkg::OP_DRAIN, 8'd0);

      // widest and tallest settings, partial frames cut short by a write
      configure(0, 0, 4095, 8191);
      for (int i = 0; i < 4; i++) queue_request(amt_pkg::OP_PIXEL, 8'd1 << i);
      configure(7, 3686, 2048, 4096);
      queue_request(amt_pkg::OP_PIXEL, 8'd200);
      configure(7, 65535, 4, 3);
      send_frame();

      while (n_req_queued < RANDOM_ITEMS) begin
         int r, w, h, scale;
         r = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6);
         if (r > 3) r = $urandom_range(0, 3);
         w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
         h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
         case ($urandom_range(0, 5))
            0:       scale = 0;
            1:       scale = 65535;
            2:       scale = $urandom_range(0, 65535);
            default: scale = $urandom_range(2500, 6000);
         endcase
         configure(r, scale, w, h);
         for (int f = $urandom_range(1, 2); f > 0; f--) begin
            if ($urandom_range(0, 9) == 0) begin
               for (int i = $urandom_range(1, 12); i > 0; i--) begin
                  queue_request(amt_pkg::operation_type'($urandom_range(0, 1)), rand_pixel());
               end
               break;
            end
            send_frame();
         end
      end

      wait_idle();
      $display("Covered %0d requests, %0d results, %0d frames, %0d register writes",
               n_req_acc, n_rsp_acc, n_frames, n_cfg_writes);
      if (n_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire
